// ----- rtl/sle_pkg.sv -----
// Package for the sequential list engine: sizes, field widths, operation and
// status codes, and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package sle_pkg;

  // List capacity and the widths that follow from it
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream beats
  localparam int KIND_W   = 2;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = 7;
  localparam int COUNT_W  = 8;

  // Common width for position / count comparisons
  localparam int CMP_W    = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] OP_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] OP_FIND   = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Memory write address selects
  localparam logic [1:0] WR_UP   = 2'd0;  // mem[ptr]     <= rdata
  localparam logic [1:0] WR_DOWN = 2'd1;  // mem[ptr - 1] <= rdata
  localparam logic [1:0] WR_PUT  = 2'd2;  // mem[pos - 1] <= value

  // Controller to datapath
  typedef struct packed {
    logic              take;
    logic              ptr_start;
    logic              ptr_inc;
    logic              ptr_dec;
    logic              rd_en;
    logic              rd_below;
    logic              wr_en;
    logic [1:0]        wr_sel;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
    logic              res_hit;
    logic              out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STAT_W-1:0] chk_status;
    logic              ptr_ge_pos;
    logic              ptr_lt_count;
    logic              hit;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/sle_ctrl.sv -----
// Controller state machine of the sequential list engine: sequences the
// check, shift, scan and result steps. Depends on sle_pkg.
`default_nettype none

module sle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sle_pkg::sts_t sts,
  output sle_pkg::cmd_t      cmd
);
  import sle_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_DEL_RD  = 4'd5;
  localparam logic [3:0] S_DEL_WR  = 4'd6;
  localparam logic [3:0] S_FND_RD  = 4'd7;
  localparam logic [3:0] S_FND_CMP = 4'd8;
  localparam logic [3:0] S_FINISH  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.chk_status != ST_OK) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = sts.chk_status;
          state_next     = S_FINISH;
        end else begin
          cmd.ptr_start = 1'b1;
          case (sts.kind)
            OP_INSERT: state_next = S_INS_RD;
            OP_DELETE: state_next = S_DEL_RD;
            default:   state_next = S_FND_RD;
          endcase
        end
      end
      // Shift entries at and above the position up by one, top first
      S_INS_RD: begin
        if (sts.ptr_ge_pos) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_below = 1'b1;
          state_next   = S_INS_WR;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_UP;
        cmd.ptr_dec = 1'b1;
        state_next  = S_INS_RD;
      end
      S_INS_PUT: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = WR_PUT;
        cmd.cnt_inc    = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_FINISH;
      end
      // Shift entries above the position down by one, bottom first
      S_DEL_RD: begin
        if (sts.ptr_lt_count) begin
          cmd.rd_en  = 1'b1;
          state_next = S_DEL_WR;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_FINISH;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_DOWN;
        cmd.ptr_inc = 1'b1;
        state_next  = S_DEL_RD;
      end
      // Scan from the bottom for the first match
      S_FND_RD: begin
        if (sts.ptr_lt_count) begin
          cmd.rd_en  = 1'b1;
          state_next = S_FND_CMP;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_NOTFOUND;
          state_next     = S_FINISH;
        end
      end
      S_FND_CMP: begin
        if (sts.hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_hit    = 1'b1;
          state_next     = S_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_FND_RD;
        end
      end
      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sle_dp.sv -----
// Datapath of the sequential list engine: list memory, entry count, walk
// pointer, checks, result and output registers. Depends on sle_pkg.
`default_nettype none

module sle_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sle_pkg::cmd_t              cmd,
  output sle_pkg::sts_t                   sts,
  input  wire logic [sle_pkg::KIND_W-1:0] in_kind,
  input  wire logic [sle_pkg::POS_W-1:0]  in_pos,
  input  wire logic [sle_pkg::VAL_W-1:0]  in_val,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [sle_pkg::STAT_W-1:0]      out_status,
  output logic [sle_pkg::IDX_W-1:0]       out_index,
  output logic [sle_pkg::COUNT_W-1:0]     out_count
);
  import sle_pkg::*;

  logic [VAL_W-1:0]  mem [CAPACITY];
  logic [VAL_W-1:0]  rdata;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  ptr_m1;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  pos;
  logic [VAL_W-1:0]  val;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_index;
  logic [CMP_W-1:0]  pos_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  pos_m1;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [STAT_W-1:0] chk_status;

  assign pos_w  = CMP_W'(pos);
  assign cnt_w  = CMP_W'(count);
  assign pos_m1 = pos_w - 1'b1;
  assign ptr_m1 = ptr - 1'b1;

  // Latch the operation
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind <= in_kind;
      pos  <= in_pos;
      val  <= in_val;
    end
  end

  // Reject bad requests before touching the list
  always_comb begin
    case (kind)
      OP_INSERT: begin
        if (count >= CNT_W'(CAPACITY)) begin
          chk_status = ST_FULL;
        end else if (pos == '0 || pos_w > cnt_w + 1'b1) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (count == '0) begin
          chk_status = ST_EMPTY;
        end else if (pos == '0 || pos_w > cnt_w) begin
          chk_status = ST_BADPOS;
        end else begin
          chk_status = ST_OK;
        end
      end
      OP_FIND: chk_status = ST_OK;
      default: chk_status = ST_BADPOS;
    endcase
  end

  // Advance the walk pointer
  always_ff @(posedge clk) begin
    if (cmd.ptr_start) begin
      case (kind)
        OP_INSERT: ptr <= count;
        OP_DELETE: ptr <= CNT_W'(pos);
        default:   ptr <= '0;
      endcase
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end else if (cmd.ptr_dec) begin
      ptr <= ptr_m1;
    end
  end

  // Memory addressing
  assign raddr = cmd.rd_below ? ptr_m1[ADDR_W-1:0] : ptr[ADDR_W-1:0];

  always_comb begin
    case (cmd.wr_sel)
      WR_UP: begin
        waddr = ptr[ADDR_W-1:0];
        wdata = rdata;
      end
      WR_DOWN: begin
        waddr = ptr_m1[ADDR_W-1:0];
        wdata = rdata;
      end
      default: begin
        waddr = pos_m1[ADDR_W-1:0];
        wdata = val;
      end
    endcase
  end

  // List memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Track the number of entries
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end else if (cmd.cnt_dec) begin
      count <= count - 1'b1;
    end
  end

  // Capture the result of the operation
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_index  <= cmd.res_hit ? IDX_W'(ptr) : '0;
    end
  end

  // Output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_index  <= res_index;
      out_count  <= COUNT_W'(count);
    end
  end

  // Status toward the controller
  always_comb begin
    sts.kind         = kind;
    sts.chk_status   = chk_status;
    sts.ptr_ge_pos   = CMP_W'(ptr) >= pos_w;
    sts.ptr_lt_count = ptr < count;
    sts.hit          = rdata == val;
    sts.out_free     = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_inc_writes: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> cmd.wr_en && cmd.wr_sel == WR_PUT && count < CNT_W'(CAPACITY))
    else $error("count grows without placing a value");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("pending result overwritten");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load && cmd.res_hit |-> ptr < count)
    else $error("match reported beyond the held entries");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> count != '0 && !cmd.cnt_inc)
    else $error("count drops on an empty list");
`endif

endmodule

`default_nettype wire

// ----- rtl/sequential_list_engine_unit.sv -----
// Top level of the sequential list engine: stream ports, field packing, and
// the controller and datapath. Depends on sle_pkg, sle_ctrl and sle_dp.
//
//  channel  | dir | beat                        | fields
//  ---------+-----+-----------------------------+-------------------------------
//  s_axis   | in  | one operation request       | tuser: kind; tdata: position,
//           |     |                             |   value
//  m_axis   | out | one result per request      | tuser: status; tdata:
//           |     |                             |   found_index, count_after
//
// One request is handled at a time. Each moved or compared entry costs a
// registered read and then a write or compare: insert moves the entries at and
// above the position, delete those above it, and find compares from the bottom
// up to the first match or through the whole list on a miss. A new request is
// taken once the previous result sits in the output register. Synchronous reset
// empties the list; a stalled output holds its beat and the engine waits.
`default_nettype none

module sequential_list_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [7:0] position, [39:8] value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [6:0] found_index, [14:7] count_after, [15] zero
  output logic [2:0]       m_axis_tuser    // [2:0] status
);
  import sle_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [IDX_W-1:0]   out_index;
  logic [COUNT_W-1:0] out_count;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (s_axis_tuser),
    .in_pos     (s_axis_tdata[7:0]),
    .in_val     (s_axis_tdata[39:8]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_index  (out_index),
    .out_count  (out_count)
  );

  // Pack the result beat
  assign m_axis_tdata = {1'b0, out_count, out_index};

endmodule

`default_nettype wire

// ----- bench/sequential_list_engine_unit_tb.sv -----
// Self-checking bench for sequential_list_engine_unit: drives list requests
// and checks every result beat against an in-bench model of the list.
// Depends on sle_pkg and the engine RTL.
`default_nettype none

module sequential_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sle_pkg::*;

  // Spare kind code: the engine must reject it
  localparam logic [KIND_W-1:0] OP_SPARE = 2'd3;

  localparam int REQ_TARGET  = 1450;
  localparam int IDLE_PCT    = 26;
  localparam int SETTLE_CYC  = 300;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    bit                drain;   // wait for all results before this beat
    bit                steady;  // no idling on either side for this beat
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [IDX_W-1:0]   found_index;
    logic [COUNT_W-1:0] count_after;
  } list_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // [7:0] position, [39:8] value
  logic [1:0]  s_axis_tuser = '0;    // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [6:0] found_index, [14:7] count_after, [15] zero
  logic [2:0]  m_axis_tuser;         // [2:0] status

  list_req_t   req_queue[$];
  list_rsp_t   rsp_expected[$];
  logic [31:0] list_mem[CAPACITY];
  int          list_len = 0;
  int          gen_len = 0;
  int          req_total = 0;
  logic [31:0] value_pool[16];
  int          mismatch_count = 0;
  bit          req_beat_taken = 1'b0;
  bit          steady_now = 1'b0;

  sequential_list_engine_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the list model and return its result
  function automatic list_rsp_t apply_list_op(logic [KIND_W-1:0] kind,
                                              logic [POS_W-1:0] position,
                                              logic [VAL_W-1:0] value);
    list_rsp_t r;
    int        i;
    int        p;
    p = position;
    r.status = ST_OK;
    r.found_index = '0;
    case (kind)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_len && r.status != ST_OK; i++) begin
          if (list_mem[i] == value) begin
            r.status = ST_OK;
            r.found_index = i[IDX_W-1:0];
          end
        end
      end
      default: r.status = ST_BADPOS;
    endcase
    r.count_after = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // Queue one request and track the list length it leaves behind
  task automatic add_req(logic [KIND_W-1:0] kind, int position, logic [VAL_W-1:0] value,
                         bit drain, bit steady);
    list_req_t q;
    q.drain = drain;
    q.steady = steady;
    q.kind = kind;
    q.position = position[POS_W-1:0];
    q.value = value;
    req_queue.push_back(q);
    req_total++;
    if (kind == OP_INSERT && gen_len < CAPACITY && position >= 1 && position <= gen_len + 1)
      gen_len++;
    else if (kind == OP_DELETE && gen_len > 0 && position >= 1 && position <= gen_len)
      gen_len--;
  endtask

  // Half the time a pool value so finds hit and duplicates occur, else random or an extreme
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return value_pool[$urandom_range(15)];
    if (r < 75) return $urandom;
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  // Mostly a legal position in 1..top, otherwise an edge or anything
  function automatic int pick_position(int top);
    int r;
    r = $urandom_range(99);
    if (r < 85 && top >= 1) return $urandom_range(top, 1);
    case ($urandom_range(3))
      0: return 0;
      1: return top + 1;
      2: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Driver: offer request beats, hold until taken
  always @(negedge clk) begin
    bit        go;
    list_req_t q;
    if (!s_axis_tvalid || req_beat_taken) begin
      req_beat_taken = 1'b0;
      go = 1'b0;
      if (!rst && req_queue.size() != 0) begin
        if (req_queue[0].drain) begin
          if (rsp_expected.size() == 0) req_queue[0].drain = 1'b0;
        end else begin
          go = req_queue[0].steady || ($urandom_range(99) >= IDLE_PCT);
        end
      end
      if (go) begin
        q = req_queue.pop_front();
        steady_now = q.steady;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q.value, q.position};
        s_axis_tuser  <= q.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= !rst && (steady_now || ($urandom_range(99) >= IDLE_PCT));
  end

  // Monitor: check result beats, then predict for a taken request beat
  always @(posedge clk) begin
    list_rsp_t got;
    list_rsp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.found_index = m_axis_tdata[6:0];
      got.count_after = m_axis_tdata[14:7];
      if (rsp_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: status %0d index %0d count %0d",
                   got.status, got.found_index, got.count_after);
      end else begin
        want = rsp_expected.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected status %0d index %0d count %0d, got %0d %0d %0d",
                     want.status, want.found_index, want.count_after,
                     got.status, got.found_index, got.count_after);
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      rsp_expected.push_back(apply_list_op(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]));
      req_beat_taken = 1'b1;
    end
  end

  // Stimulus: directed requests, then random phases
  initial begin
    int  phase_no;
    int  mode;
    int  n;
    int  k;
    bit  drain;
    bit  steady;
    for (n = 0; n < 16; n++) value_pool[n] = $urandom;

    // empty list, bad positions, extremes, duplicates, spare kind
    add_req(OP_FIND,   0,   32'd5,         0, 0);
    add_req(OP_DELETE, 1,   32'd0,         0, 0);
    add_req(OP_DELETE, 0,   32'd0,         0, 0);
    add_req(OP_INSERT, 0,   32'd1,         0, 0);
    add_req(OP_INSERT, 2,   32'd1,         0, 0);
    add_req(OP_INSERT, 1,   32'h8000_0000, 0, 0);
    add_req(OP_INSERT, 2,   32'h7FFF_FFFF, 0, 0);
    add_req(OP_INSERT, 1,   32'hFFFF_FFFF, 0, 0);
    add_req(OP_INSERT, 3,   32'h0000_0000, 0, 0);
    add_req(OP_INSERT, 255, 32'd7,         0, 0);
    add_req(OP_INSERT, 6,   32'd7,         0, 0);
    add_req(OP_FIND,   0,   32'h7FFF_FFFF, 0, 0);
    add_req(OP_FIND,   0,   32'hFFFF_FFFF, 0, 0);
    add_req(OP_INSERT, 5,   32'h0000_0000, 0, 0);
    add_req(OP_FIND,   0,   32'h0000_0000, 0, 0);
    add_req(OP_FIND,   0,   32'd12345,     0, 0);
    add_req(OP_DELETE, 0,   32'd0,         0, 0);
    add_req(OP_DELETE, 6,   32'd0,         0, 0);
    add_req(OP_DELETE, 255, 32'd0,         0, 0);
    add_req(OP_SPARE,  1,   32'd0,         0, 0);
    add_req(OP_SPARE,  255, 32'hFFFF_FFFF, 0, 0);
    add_req(OP_DELETE, 1,   32'd0,         0, 0);
    add_req(OP_DELETE, 4,   32'd0,         0, 0);
    add_req(OP_FIND,   255, 32'h8000_0000, 0, 0);

    // random phases: fill to full, drain to empty, or a mixed walk
    phase_no = 0;
    while (req_total < REQ_TARGET) begin
      drain = (phase_no == 0) || ($urandom_range(99) < 30);
      steady = (phase_no == 1);
      if (phase_no == 1) mode = 0;
      else if (phase_no == 4) mode = 1;
      else begin
        k = $urandom_range(99);
        mode = (k < 12) ? 0 : (k < 30) ? 1 : 2;
      end
      case (mode)
        0: begin
          while (gen_len < CAPACITY) begin
            add_req(OP_INSERT, $urandom_range(gen_len + 1, 1), pick_value(), drain, steady);
            drain = 0;
          end
          add_req(OP_INSERT, CAPACITY + 1, pick_value(), 0, steady);
          add_req(OP_INSERT, $urandom_range(255), pick_value(), 0, steady);
          add_req(OP_FIND, $urandom_range(255), pick_value(), 0, steady);
        end
        1: begin
          while (gen_len > 0) begin
            add_req(OP_DELETE, $urandom_range(gen_len, 1), 32'(pick_value()), drain, steady);
            drain = 0;
          end
          add_req(OP_DELETE, pick_position(0), $urandom, drain, steady);
          add_req(OP_FIND, $urandom_range(255), pick_value(), 0, steady);
        end
        default: begin
          for (n = $urandom_range(80, 40); n > 0; n--) begin
            k = $urandom_range(99);
            if (k < 40)
              add_req(OP_INSERT, pick_position(gen_len + 1), pick_value(), drain, steady);
            else if (k < 70)
              add_req(OP_DELETE, pick_position(gen_len), $urandom, drain, steady);
            else if (k < 95)
              add_req(OP_FIND, $urandom_range(255), pick_value(), drain, steady);
            else
              add_req(OP_SPARE, $urandom_range(255), $urandom, drain, steady);
            drain = 0;
          end
        end
      endcase
      phase_no++;
    end

    // release reset
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // wait for every request to go out and every result to come back
    while (req_queue.size() != 0 || s_axis_tvalid || rsp_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
